FILE: src/gsg_pkg.sv
package gsg_pkg;

    // Field widths
    localparam int COORD_W    = 8;
    localparam int SIZE_W     = 9;
    localparam int IDX_W      = 24;
    localparam int COUNT_W    = 26;
    localparam int STEP_W     = 32;
    localparam int COEFF_W    = 33;
    localparam int SEL_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Products: nx*ny, y*nx and z*(nx*ny)
    localparam int NXNY_W = 2 * SIZE_W;
    localparam int YNX_W  = COORD_W + SIZE_W;
    localparam int ZPROD_W = COORD_W + NXNY_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCHEME   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP = 3'd5;

    // Axis codes
    localparam logic [SEL_W-1:0] AXIS_X = 2'd0;
    localparam logic [SEL_W-1:0] AXIS_Y = 2'd1;
    localparam logic [SEL_W-1:0] AXIS_Z = 2'd2;

    // Scheme codes
    localparam logic [SEL_W-1:0] SCHEME_CENTRAL  = 2'd0;
    localparam logic [SEL_W-1:0] SCHEME_UPWIND   = 2'd1;
    localparam logic [SEL_W-1:0] SCHEME_DOWNWIND = 2'd2;

    // Reset values of the configuration registers
    localparam logic [SIZE_W-1:0] SIZE_RESET     = 9'd1;
    localparam logic [STEP_W-1:0] INV_STEP_RESET = 32'd65536;

    typedef struct packed {
        logic capture;
        logic mul_a;
        logic mul_b;
        logic sum;
        logic load_lo;
        logic load_hi;
    } gsg_cmd_t;

    typedef struct packed {
        logic has_lo;
        logic has_hi;
        logic out_free;
    } gsg_status_t;

endpackage

FILE: src/gsg_ctrl.sv
module gsg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gsg_pkg::gsg_status_t status,
    output gsg_pkg::gsg_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL_A = 6'b000010,
        ST_MUL_B = 6'b000100,
        ST_SUM   = 6'b001000,
        ST_LO    = 6'b010000,
        ST_HI    = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                cmd.mul_a  = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                cmd.mul_b  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum = 1'b1;
                if (status.has_lo) begin
                    state_next = ST_LO;
                end else if (status.has_hi) begin
                    state_next = ST_HI;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_LO: begin
                if (status.out_free) begin
                    cmd.load_lo = 1'b1;
                    state_next  = status.has_hi ? ST_HI : ST_IDLE;
                end
            end
            ST_HI: begin
                if (status.out_free) begin
                    cmd.load_hi = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/gsg_dp.sv
module gsg_dp #(
    parameter int MAX_DIM = 256
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration writes
    input  logic                                   cfg_we,
    input  logic [gsg_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [gsg_pkg::CFG_DATA_W-1:0]         cfg_data,
    // input payload
    input  logic [gsg_pkg::COORD_W-1:0]            s_point_x,
    input  logic [gsg_pkg::COORD_W-1:0]            s_point_y,
    input  logic [gsg_pkg::COORD_W-1:0]            s_point_z,
    input  logic                                   s_first,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [gsg_pkg::IDX_W-1:0]              m_row,
    output logic [gsg_pkg::IDX_W-1:0]              m_column,
    output logic signed [gsg_pkg::COEFF_W-1:0]     m_coeff,
    output logic [gsg_pkg::COUNT_W-1:0]            m_row_end,
    output logic                                   m_last,
    // controller link
    input  gsg_pkg::gsg_cmd_t                      cmd,
    output gsg_pkg::gsg_status_t                   status
);

    // Configuration registers
    logic [gsg_pkg::SIZE_W-1:0]  size_x_reg;
    logic [gsg_pkg::SIZE_W-1:0]  size_y_reg;
    logic [gsg_pkg::SIZE_W-1:0]  size_z_reg;
    logic [gsg_pkg::SEL_W-1:0]   axis_reg;
    logic [gsg_pkg::SEL_W-1:0]   scheme_reg;
    logic [gsg_pkg::STEP_W-1:0]  inv_step_reg;

    // Item registers
    logic [gsg_pkg::COORD_W-1:0] px_reg;
    logic [gsg_pkg::COORD_W-1:0] py_reg;
    logic [gsg_pkg::COORD_W-1:0] pz_reg;
    logic [gsg_pkg::NXNY_W-1:0]  nxny_reg;
    logic [gsg_pkg::YNX_W-1:0]   ynx_reg;
    logic [gsg_pkg::IDX_W-1:0]   zterm_reg;
    logic [gsg_pkg::IDX_W-1:0]   row_reg;
    logic [gsg_pkg::IDX_W-1:0]   stride_reg;
    logic [gsg_pkg::COUNT_W-1:0] count_reg;
    logic [gsg_pkg::COUNT_W-1:0] count_next;

    // Output register
    logic                        m_valid_reg;
    logic [gsg_pkg::IDX_W-1:0]   m_row_reg;
    logic [gsg_pkg::IDX_W-1:0]   m_column_reg;
    logic [gsg_pkg::COEFF_W-1:0] m_coeff_reg;
    logic [gsg_pkg::COUNT_W-1:0] m_row_end_reg;
    logic                        m_last_reg;

    logic [gsg_pkg::SIZE_W-1:0]  nx;
    logic [gsg_pkg::SIZE_W-1:0]  ny;
    logic [gsg_pkg::SIZE_W-1:0]  nz;
    logic [gsg_pkg::SIZE_W-1:0]  n_axis;
    logic [gsg_pkg::COORD_W-1:0] p_axis;
    logic                        axis_ok;
    logic [gsg_pkg::NXNY_W-1:0]  nxny_next;
    logic [gsg_pkg::YNX_W-1:0]   ynx_next;
    logic [gsg_pkg::ZPROD_W-1:0] zprod;
    logic [gsg_pkg::IDX_W-1:0]   row_next;
    logic [gsg_pkg::IDX_W-1:0]   stride_next;
    logic [gsg_pkg::IDX_W-1:0]   lcol;
    logic [gsg_pkg::IDX_W-1:0]   hcol;
    logic [gsg_pkg::COEFF_W-1:0] pos_coeff;
    logic [gsg_pkg::COEFF_W-1:0] neg_coeff;

    // A size of zero acts as one, a size above MAX_DIM acts as MAX_DIM.
    function automatic logic [gsg_pkg::SIZE_W-1:0] eff_size(
        input logic [gsg_pkg::SIZE_W-1:0] s
    );
        logic [gsg_pkg::SIZE_W-1:0] r;
        if (s == '0) begin
            r = gsg_pkg::SIZE_W'(1);
        end else if (32'(s) > MAX_DIM) begin
            r = gsg_pkg::SIZE_W'(MAX_DIM);
        end else begin
            r = s;
        end
        return r;
    endfunction

    assign nx = eff_size(size_x_reg);
    assign ny = eff_size(size_y_reg);
    assign nz = eff_size(size_z_reg);

    always_comb begin
        axis_ok = 1'b1;
        case (axis_reg)
            gsg_pkg::AXIS_X: begin
                p_axis = px_reg;
                n_axis = nx;
            end
            gsg_pkg::AXIS_Y: begin
                p_axis = py_reg;
                n_axis = ny;
            end
            gsg_pkg::AXIS_Z: begin
                p_axis = pz_reg;
                n_axis = nz;
            end
            default: begin
                p_axis  = '0;
                n_axis  = gsg_pkg::SIZE_W'(1);
                axis_ok = 1'b0;
            end
        endcase
    end

    assign status.has_lo   = axis_ok && (p_axis != '0);
    assign status.has_hi   = axis_ok &&
                             ({1'b0, p_axis} < (n_axis - gsg_pkg::SIZE_W'(1)));
    assign status.out_free = !m_valid_reg || m_ready;

    // Arithmetic chain: products, then the z term, then the sum.
    assign nxny_next = nx * ny;
    assign ynx_next  = py_reg * nx;
    assign zprod     = pz_reg * nxny_reg;
    assign row_next  = gsg_pkg::IDX_W'(px_reg) + gsg_pkg::IDX_W'(ynx_reg) + zterm_reg;

    always_comb begin
        case (axis_reg)
            gsg_pkg::AXIS_Y: stride_next = gsg_pkg::IDX_W'(nx);
            gsg_pkg::AXIS_Z: stride_next = gsg_pkg::IDX_W'(nxny_reg);
            default:         stride_next = gsg_pkg::IDX_W'(1);
        endcase
    end

    // Upwind points the upper entry at the point itself, downwind the lower one.
    assign lcol = (scheme_reg == gsg_pkg::SCHEME_DOWNWIND) ? row_reg : row_reg - stride_reg;
    assign hcol = (scheme_reg == gsg_pkg::SCHEME_UPWIND)   ? row_reg : row_reg + stride_reg;

    assign pos_coeff = {1'b0, inv_step_reg};
    assign neg_coeff = gsg_pkg::COEFF_W'(0) - pos_coeff;

    assign count_next = (count_reg == '1) ? count_reg : count_reg + gsg_pkg::COUNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg   <= gsg_pkg::SIZE_RESET;
            size_y_reg   <= gsg_pkg::SIZE_RESET;
            size_z_reg   <= gsg_pkg::SIZE_RESET;
            axis_reg     <= gsg_pkg::AXIS_X;
            scheme_reg   <= gsg_pkg::SCHEME_CENTRAL;
            inv_step_reg <= gsg_pkg::INV_STEP_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                gsg_pkg::REG_SIZE_X:   size_x_reg   <= cfg_data[gsg_pkg::SIZE_W-1:0];
                gsg_pkg::REG_SIZE_Y:   size_y_reg   <= cfg_data[gsg_pkg::SIZE_W-1:0];
                gsg_pkg::REG_SIZE_Z:   size_z_reg   <= cfg_data[gsg_pkg::SIZE_W-1:0];
                gsg_pkg::REG_AXIS:     axis_reg     <= cfg_data[gsg_pkg::SEL_W-1:0];
                gsg_pkg::REG_SCHEME:   scheme_reg   <= cfg_data[gsg_pkg::SEL_W-1:0];
                gsg_pkg::REG_INV_STEP: inv_step_reg <= cfg_data[gsg_pkg::STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.capture && s_first) begin
                count_reg <= '0;
            end else if (cmd.load_lo || cmd.load_hi) begin
                count_reg <= count_next;
            end
            if (cmd.load_lo || cmd.load_hi) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            px_reg <= s_point_x;
            py_reg <= s_point_y;
            pz_reg <= s_point_z;
        end
        if (cmd.mul_a) begin
            nxny_reg <= nxny_next;
            ynx_reg  <= ynx_next;
        end
        if (cmd.mul_b) begin
            zterm_reg <= zprod[gsg_pkg::IDX_W-1:0];
        end
        if (cmd.sum) begin
            row_reg    <= row_next;
            stride_reg <= stride_next;
        end
        if (cmd.load_lo) begin
            m_row_reg     <= row_reg;
            m_column_reg  <= lcol;
            m_coeff_reg   <= neg_coeff;
            m_row_end_reg <= count_next;
            m_last_reg    <= !status.has_hi;
        end else if (cmd.load_hi) begin
            m_row_reg     <= row_reg;
            m_column_reg  <= hcol;
            m_coeff_reg   <= pos_coeff;
            m_row_end_reg <= count_next;
            m_last_reg    <= 1'b1;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_row     = m_row_reg;
    assign m_column  = m_column_reg;
    assign m_coeff   = $signed(m_coeff_reg);
    assign m_row_end = m_row_end_reg;
    assign m_last    = m_last_reg;

`ifndef SYNTHESIS
    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_lo || cmd.load_hi) |-> (!m_valid_reg || m_ready))
        else $error("entry loaded over an untaken result");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.load_lo, cmd.load_hi}))
        else $error("capture and entry load overlap");

    a_lower_has_lo: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_lo |-> status.has_lo)
        else $error("lower entry without a lower neighbour");

    a_upper_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_hi |=> (m_last_reg && m_valid_reg))
        else $error("upper entry not marked as last");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_lo || cmd.load_hi) |=> (count_reg != '0 && m_row_end_reg == count_reg))
        else $error("row end pointer does not follow the entry counter");
`endif

endmodule

FILE: src/gradient_stencil_csr_generator.sv
// Channel   Handshake                Payload
// input     s_valid / s_ready        s_point_x, s_point_y, s_point_z, s_first
// result    m_valid / m_ready        m_row, m_column, m_coeff, m_row_end, m_last
// config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// After acceptance a grid point passes through the index arithmetic, then the controller loads
// each matrix entry it produces, none, one or two, into the output register.
// The arithmetic registers nx*ny and y*nx, then the product z*(nx*ny), then the final sum;
// the single output register takes one entry a cycle while m_ready does not stall it.
// Reset is synchronous and active low; it returns the configuration registers to their
// defaults and clears the entry counter and the output valid flag.
// A stall on m_ready holds the controller in its entry state; s_ready is low until the
// last entry of the current point has been loaded into the output register.
module gradient_stencil_csr_generator #(
    parameter int MAX_DIM = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gsg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gsg_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [gsg_pkg::COORD_W-1:0]         s_point_x,
    input  logic [gsg_pkg::COORD_W-1:0]         s_point_y,
    input  logic [gsg_pkg::COORD_W-1:0]         s_point_z,
    input  logic                                s_first,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gsg_pkg::IDX_W-1:0]           m_row,
    output logic [gsg_pkg::IDX_W-1:0]           m_column,
    output logic signed [gsg_pkg::COEFF_W-1:0]  m_coeff,
    output logic [gsg_pkg::COUNT_W-1:0]         m_row_end,
    output logic                                m_last
);

    gsg_pkg::gsg_cmd_t    cmd;
    gsg_pkg::gsg_status_t status;

    // Configuration registers are plain flops, so every write beat is taken at once.
    assign cfg_ready = 1'b1;

    // The controller sequences capture, the two multiply stages, the sum and
    // the entry loads, none, one or two, of each point.
    gsg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the configuration, the index arithmetic, the entry
    // counter and the output register.
    gsg_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_point_x (s_point_x),
        .s_point_y (s_point_y),
        .s_point_z (s_point_z),
        .s_first   (s_first),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_row     (m_row),
        .m_column  (m_column),
        .m_coeff   (m_coeff),
        .m_row_end (m_row_end),
        .m_last    (m_last),
        .cmd       (cmd),
        .status    (status)
    );

`ifndef SYNTHESIS
    a_no_accept_while_emitting: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second point accepted before the first was processed");

    a_cfg_always_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port stalled");

    a_beat_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> ##2 !s_ready)
        else $error("index arithmetic cut short");
`endif

endmodule
